// ----- sv/quadratic_root_solver_defines.svh -----
// ----------------------------------------------------------------------------
// quadratic_root_solver_defines
// Shared assertion macros for the quadratic root solver.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define QRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define QRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Types and constants shared by the quadratic root solver modules.
// ----------------------------------------------------------------------------
package qrs_pkg;
    localparam int OUT_WIDTH = 34;

    typedef enum logic [1:0] {
        KIND_DEGEN   = 2'd0,
        KIND_DOUBLE  = 2'd1,
        KIND_REAL    = 2'd2,
        KIND_COMPLEX = 2'd3
    } t_kind;
endpackage

// ----- sv/qrs_sqrt.sv -----
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
    parameter int ROOT_W = 33,
    parameter int SIDE_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [2*ROOT_W-1:0]  i_rad,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [ROOT_W-1:0]    o_root,
    output logic [SIDE_W-1:0]    o_side
);
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [ROOT_W:1]            r_vld;
    logic [RAD_W-1:0]           r_rad  [1:ROOT_W];
    logic [REM_W-1:0]           r_rem  [1:ROOT_W];
    logic [ROOT_W-1:0]          r_root [1:ROOT_W];
    logic [SIDE_W-1:0]          r_side [1:ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic                 w_vld;
        logic [RAD_W-1:0]     w_rad;
        logic [REM_W-1:0]     w_rem;
        logic [ROOT_W-1:0]    w_root;
        logic [SIDE_W-1:0]    w_side;
        logic [REM_W-1:0]     n_rem_sh;
        logic [REM_W-1:0]     n_trial;

        if (g == 0) begin : g_head
            assign w_vld  = i_valid;
            assign w_rad  = i_rad;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_side = i_side;
        end else begin : g_body
            assign w_vld  = r_vld[g];
            assign w_rad  = r_rad[g];
            assign w_rem  = r_rem[g];
            assign w_root = r_root[g];
            assign w_side = r_side[g];
        end

        always_comb begin
            n_rem_sh = {w_rem[REM_W-3:0], w_rad[RAD_W-1 -: 2]};
            n_trial  = {w_root, 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= w_vld;
            end
            r_rad[g+1]  <= {w_rad[RAD_W-3:0], 2'b00};
            r_side[g+1] <= w_side;
            if (n_rem_sh >= n_trial) begin
                r_rem[g+1]  <= n_rem_sh - n_trial;
                r_root[g+1] <= {w_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem[g+1]  <= n_rem_sh;
                r_root[g+1] <= {w_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_side  = r_side[ROOT_W];
endmodule

// ----- sv/qrs_div.sv -----
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined signed divider truncating toward zero, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int NUM_W  = 50,
    parameter int DEN_W  = 18,
    parameter int SIDE_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [NUM_W-1:0]  i_num,
    input  logic signed [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic signed [NUM_W-1:0]  o_quot,
    output logic [SIDE_W-1:0]        o_side
);
    localparam int REM_W = DEN_W + 1;

    logic [NUM_W:1]        r_vld;
    logic [NUM_W-1:0]      r_num  [1:NUM_W];
    logic [REM_W-1:0]      r_rem  [1:NUM_W];
    logic [DEN_W-1:0]      r_den  [1:NUM_W];
    logic                  r_neg  [1:NUM_W];
    logic [SIDE_W-1:0]     r_side [1:NUM_W];

    logic [NUM_W-1:0]      n_num0;
    logic [DEN_W-1:0]      n_den0;
    logic                  n_neg0;

    always_comb begin
        n_num0 = i_num[NUM_W-1] ? NUM_W'(-i_num) : i_num;
        n_den0 = i_den[DEN_W-1] ? DEN_W'(-i_den) : i_den;
        n_neg0 = i_num[NUM_W-1] ^ i_den[DEN_W-1];
    end

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic                 w_vld;
        logic [NUM_W-1:0]     w_num;
        logic [REM_W-1:0]     w_rem;
        logic [DEN_W-1:0]     w_den;
        logic                 w_neg;
        logic [SIDE_W-1:0]    w_side;
        logic [REM_W-1:0]     n_sh;

        if (g == 0) begin : g_head
            assign w_vld  = i_valid;
            assign w_num  = n_num0;
            assign w_rem  = '0;
            assign w_den  = n_den0;
            assign w_neg  = n_neg0;
            assign w_side = i_side;
        end else begin : g_body
            assign w_vld  = r_vld[g];
            assign w_num  = r_num[g];
            assign w_rem  = r_rem[g];
            assign w_den  = r_den[g];
            assign w_neg  = r_neg[g];
            assign w_side = r_side[g];
        end

        assign n_sh = {w_rem[REM_W-2:0], w_num[NUM_W-1]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= w_vld;
            end
            r_den[g+1]  <= w_den;
            r_neg[g+1]  <= w_neg;
            r_side[g+1] <= w_side;
            // The shifted-out numerator bits make room for quotient bits.
            if (n_sh >= {1'b0, w_den}) begin
                r_rem[g+1] <= n_sh - {1'b0, w_den};
                r_num[g+1] <= {w_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem[g+1] <= n_sh;
                r_num[g+1] <= {w_num[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quot  = r_neg[NUM_W] ? NUM_W'(-r_num[NUM_W]) : r_num[NUM_W];
    assign o_side  = r_side[NUM_W];
endmodule

// ----- sv/quadratic_root_solver.sv -----
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Streams roots of a*x^2 + b*x + c = 0 in signed fixed point.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// command   in         i_start & !o_busy     i_coef_quad, i_coef_lin, i_coef_const
// result    out        o_done (one cycle)    o_root_kind, o_first_value, o_second_value
//
// One transaction enters per cycle; o_busy is always low.
// Stages: products, discriminant, (COEF_WIDTH+FRAC_BITS+1) square root stages,
// numerators, (COEF_WIDTH+2*FRAC_BITS+3) divider stages and the output register.
// Reset clears only the valid bits of the pipeline.
// Results cannot be stalled and leave exactly one cycle each.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic signed [COEF_WIDTH-1:0]      i_coef_quad,
    input  logic signed [COEF_WIDTH-1:0]      i_coef_lin,
    input  logic signed [COEF_WIDTH-1:0]      i_coef_const,
    output logic                              o_done,
    output logic [1:0]                        o_root_kind,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0] o_first_value,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0] o_second_value
);
    import qrs_pkg::*;
    `include "quadratic_root_solver_defines.svh"

    localparam int DW    = 2 * COEF_WIDTH + 2;          // delta width, signed
    localparam int RT_W  = COEF_WIDTH + FRAC_BITS + 1;  // root width
    localparam int NB_W  = COEF_WIDTH + 1 + FRAC_BITS;  // -b scaled
    localparam int NUM_W = RT_W + FRAC_BITS + 2;        // numerator width
    localparam int DEN_W = COEF_WIDTH + 1;
    localparam int SIDE_W = 2 + NUM_W + DEN_W;
    localparam int DSIDE_W = 2;
    localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    assign o_busy = 1'b0;

    // Stage 1: products.
    logic                      r_v1;
    logic signed [DW-1:0]      r_bb, r_ac;
    logic signed [COEF_WIDTH-1:0] r_a1, r_b1;
    logic signed [2*COEF_WIDTH-1:0] n_bb, n_ac;
    always_comb begin
        n_bb = i_coef_lin * i_coef_lin;
        n_ac = i_coef_quad * i_coef_const;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_start;
        end
        r_bb <= DW'(n_bb);
        r_ac <= DW'(n_ac);
        r_a1 <= i_coef_quad;
        r_b1 <= i_coef_lin;
    end

    // Stage 2: discriminant and its magnitude.
    logic                      r_v2;
    logic signed [DW-1:0]      r_dl;
    logic [2*RT_W-1:0]         r_rad;
    logic signed [COEF_WIDTH-1:0] r_a2, r_b2;
    logic signed [DW-1:0]      n_dl;
    logic [DW-1:0]             n_mag;
    always_comb begin
        n_dl  = r_bb - (r_ac <<< 2);
        n_mag = n_dl[DW-1] ? DW'(-n_dl) : n_dl;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_dl  <= n_dl;
        r_rad <= (2*RT_W)'(n_mag) << (2 * FRAC_BITS);
        r_a2  <= r_a1;
        r_b2  <= r_b1;
    end

    // Stage 3: square root pipeline; kind and operands ride along.
    t_kind n_kind2;
    always_comb begin
        priority if (r_a2 == '0)   n_kind2 = KIND_DEGEN;
        else if (r_dl == '0)       n_kind2 = KIND_DOUBLE;
        else if (!r_dl[DW-1])      n_kind2 = KIND_REAL;
        else                       n_kind2 = KIND_COMPLEX;
    end

    logic [SIDE_W-1:0] n_sq_side, w_sq_side;
    logic              w_sq_v;
    logic [RT_W-1:0]   w_root;
    logic signed [NUM_W-1:0] n_nb;
    logic signed [DEN_W-1:0] n_twoa;
    always_comb begin
        n_nb   = NUM_W'(-(NB_W'(r_b2)) <<< FRAC_BITS);
        n_twoa = DEN_W'(r_a2) <<< 1;
        n_sq_side = {n_kind2, n_nb, n_twoa};
    end

    qrs_sqrt #(.ROOT_W(RT_W), .SIDE_W(SIDE_W)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v2), .i_rad(r_rad),
        .i_side(n_sq_side), .o_valid(w_sq_v), .o_root(w_root), .o_side(w_sq_side)
    );

    // Stage 4: form numerators.
    logic                    r_v4;
    t_kind                   r_k4;
    logic signed [NUM_W-1:0] r_n1, r_n2;
    logic signed [DEN_W-1:0] r_den4;
    t_kind                   w_k3;
    logic signed [NUM_W-1:0] w_nb3, w_s;
    logic signed [DEN_W-1:0] w_den3;
    always_comb begin
        w_k3   = t_kind'(w_sq_side[SIDE_W-1 -: 2]);
        w_nb3  = w_sq_side[DEN_W+NUM_W-1 -: NUM_W];
        w_den3 = w_sq_side[DEN_W-1:0];
        w_s    = NUM_W'(w_root);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= w_sq_v;
        end
        r_k4 <= w_k3;
        // A zero divisor is replaced by one; the numerators are zeroed here, so the result is zero.
        r_den4 <= (w_k3 == KIND_DEGEN) ? DEN_W'(1) : w_den3;
        unique case (w_k3)
            KIND_DEGEN: begin
                r_n1 <= '0;
                r_n2 <= '0;
            end
            KIND_DOUBLE: begin
                r_n1 <= w_nb3;
                r_n2 <= w_nb3;
            end
            KIND_REAL: begin
                r_n1 <= w_nb3 + w_s;
                r_n2 <= w_nb3 - w_s;
            end
            default: begin
                r_n1 <= w_nb3;
                r_n2 <= w_s;
            end
        endcase
    end

    // Two dividers in parallel.
    logic                    w_d1_v, w_d2_v;
    logic signed [NUM_W-1:0] w_q1, w_q2;
    logic [DSIDE_W-1:0]      w_d1_side, w_d2_side;
    qrs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(DSIDE_W)) u_div1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v4), .i_num(r_n1),
        .i_den(r_den4), .i_side(r_k4), .o_valid(w_d1_v), .o_quot(w_q1),
        .o_side(w_d1_side)
    );
    qrs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(DSIDE_W)) u_div2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v4), .i_num(r_n2),
        .i_den(r_den4), .i_side(r_k4), .o_valid(w_d2_v), .o_quot(w_q2),
        .o_side(w_d2_side)
    );

    // Output stage with saturation.
    function automatic logic signed [OUT_WIDTH-1:0] sat(input logic signed [NUM_W-1:0] v);
        logic signed [NUM_W+OUT_WIDTH-1:0] x;
        x = (NUM_W+OUT_WIDTH)'(v);
        if (x > (NUM_W+OUT_WIDTH)'(OUT_MAX)) return OUT_MAX;
        if (x < (NUM_W+OUT_WIDTH)'(OUT_MIN)) return OUT_MIN;
        return OUT_WIDTH'(x);
    endfunction

    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_d1_v;
        end
        o_root_kind    <= w_d1_side;
        o_first_value  <= sat(w_q1);
        o_second_value <= sat(w_q2);
    end
    assign o_done = r_done;

    `QRS_ASSERT_IMP(a_div_lockstep, i_clk, i_rst_n, w_d1_v != w_d2_v, 1'b0,
        "dividers out of step")
    `QRS_ASSERT_IMP(a_side_match, i_clk, i_rst_n, w_d1_v, w_d1_side == w_d2_side,
        "divider kinds differ")
    `QRS_ASSERT_NEXT(a_degen_zero, i_clk, i_rst_n, w_d1_v && w_d1_side == KIND_DEGEN,
        o_first_value == '0 && o_second_value == '0, "degenerate result not zero")
    `QRS_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, w_d1_v, o_done,
        "result strobe missing")
endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quadratic_root_solver. A short table of directed
// coefficient sets is followed by random sets in several idling phases; every
// result is compared, in order, with the table's value or a local fixed-point solver.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qrs_pkg::*;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
    } t_coef_set;

    typedef struct {
        t_kind                        kind;
        logic signed [OUT_WIDTH-1:0]  v1;
        logic signed [OUT_WIDTH-1:0]  v2;
    } t_roots;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        bit                 typed;
        t_roots             want;
    } t_table_row;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 150;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic signed [15:0] i_coef_quad = '0;
    logic signed [15:0] i_coef_lin = '0;
    logic signed [15:0] i_coef_const = '0;
    logic o_busy;
    logic o_done;
    logic [1:0] o_root_kind;
    logic signed [OUT_WIDTH-1:0] o_first_value;
    logic signed [OUT_WIDTH-1:0] o_second_value;

    t_roots pending_roots[$];
    int     mismatches = 0;
    int     cycle_count = 0;

    quadratic_root_solver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_coef_quad    (i_coef_quad),
        .i_coef_lin     (i_coef_lin),
        .i_coef_const   (i_coef_const),
        .o_done         (o_done),
        .o_root_kind    (o_root_kind),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // floor(sqrt(d * 2^32)), one root bit per step.
    function automatic longint sqrt_q16(input longint unsigned d);
        bit [79:0] rem;
        bit [79:0] trial;
        bit [79:0] root;
        bit [79:0] pair;
        rem = '0;
        root = '0;
        for (int i = 47; i >= 0; i--) begin
            pair = (i >= 16) ? ((80'(d) >> (2 * (i - 16))) & 80'd3) : 80'd0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 80'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 80'd1;
            end else begin
                root = root << 1;
            end
        end
        return longint'(root);
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] clamp_out(input longint v);
        longint hi;
        hi = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[OUT_WIDTH-1:0];
    endfunction

    function automatic t_roots solve_roots(input t_coef_set cs);
        t_roots r;
        longint a, b, c, delta, twoa, nb, s;
        a = cs.a;
        b = cs.b;
        c = cs.c;
        if (a == 0) begin
            r.kind = KIND_DEGEN;
            r.v1 = '0;
            r.v2 = '0;
            return r;
        end
        delta = b * b - 4 * a * c;
        twoa = 2 * a;
        nb = (-b) * 65536;
        if (delta == 0) begin
            r.kind = KIND_DOUBLE;
            r.v1 = clamp_out(nb / twoa);
            r.v2 = r.v1;
        end else if (delta > 0) begin
            r.kind = KIND_REAL;
            s = sqrt_q16(delta);
            r.v1 = clamp_out((nb + s) / twoa);
            r.v2 = clamp_out((nb - s) / twoa);
        end else begin
            r.kind = KIND_COMPLEX;
            s = sqrt_q16(-delta);
            r.v1 = clamp_out(nb / twoa);
            r.v2 = clamp_out(s / twoa);
        end
        return r;
    endfunction

    // Holds start high until the transaction is taken, then records its roots.
    task automatic issue_coefs(input t_coef_set cs, input bit typed, input t_roots want);
        i_start <= 1'b1;
        i_coef_quad <= cs.a;
        i_coef_lin <= cs.b;
        i_coef_const <= cs.c;
        do @(posedge i_clk); while (o_busy);
        pending_roots.push_back(typed ? want : solve_roots(cs));
    endtask

    task automatic idle_for(input int n);
        i_start <= 1'b0;
        i_coef_quad <= 16'($urandom);
        i_coef_lin <= 16'($urandom);
        i_coef_const <= 16'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_roots.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_coef_set random_coefs();
        t_coef_set cs;
        int k, m;
        case ($urandom_range(0, 4))
            0, 1: begin
                cs.a = 16'($urandom);
                cs.b = 16'($urandom);
                cs.c = 16'($urandom);
            end
            2: begin
                cs.a = 16'($signed($urandom_range(0, 16)) - 8);
                cs.b = 16'($signed($urandom_range(0, 16)) - 8);
                cs.c = 16'($signed($urandom_range(0, 16)) - 8);
            end
            3: begin
                // Perfect square k*(x+m)^2 gives a double root.
                k = $urandom_range(0, 40) - 20;
                m = $urandom_range(0, 40) - 20;
                cs.a = 16'(k);
                cs.b = 16'(2 * k * m);
                cs.c = 16'(k * m * m);
            end
            default: begin
                cs.a = 16'($signed($urandom_range(0, 512)) - 256);
                cs.b = 16'($urandom);
                cs.c = 16'($signed($urandom_range(0, 512)) - 256);
            end
        endcase
        return cs;
    endfunction

    always @(posedge i_clk) begin
        t_roots exp_r;
        if (i_rst_n && o_done) begin
            if (pending_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: kind=%0d v1=%0d v2=%0d",
                             o_root_kind, o_first_value, o_second_value);
            end else begin
                exp_r = pending_roots.pop_front();
                if (o_root_kind !== exp_r.kind || o_first_value !== exp_r.v1
                        || o_second_value !== exp_r.v2) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: kind %0d/%0d v1 %0d/%0d v2 %0d/%0d (exp/act)",
                                 exp_r.kind, o_root_kind, exp_r.v1, o_first_value,
                                 exp_r.v2, o_second_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_table_row rows[$];
        t_coef_set  cs;
        t_roots     none;
        int         idle_pct;
        none = '{KIND_DEGEN, '0, '0};
        rows = '{
            '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{KIND_DEGEN, 34'sd0, 34'sd0}},
            '{16'sd0, 16'sh7fff, -16'sd32768, 1'b1, '{KIND_DEGEN, 34'sd0, 34'sd0}},
            '{16'sd1, 16'sd0, 16'sd0, 1'b1, '{KIND_DOUBLE, 34'sd0, 34'sd0}},
            '{16'sd1, -16'sd2, 16'sd1, 1'b1, '{KIND_DOUBLE, 34'sd65536, 34'sd65536}},
            '{16'sd1, 16'sd0, -16'sd1, 1'b1, '{KIND_REAL, 34'sd65536, -34'sd65536}},
            '{16'sd1, 16'sd0, 16'sd1, 1'b1, '{KIND_COMPLEX, 34'sd0, 34'sd65536}},
            // Negative a with complex roots: the imaginary part comes out negative.
            '{-16'sd1, 16'sd0, -16'sd1, 1'b1, '{KIND_COMPLEX, 34'sd0, -34'sd65536}},
            '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, none},
            '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, none},
            '{16'sh7fff, -16'sd32768, -16'sd32768, 1'b0, none},
            '{-16'sd32768, 16'sh7fff, 16'sh7fff, 1'b0, none},
            '{16'sd1, -16'sd32768, 16'sh7fff, 1'b0, none},
            '{16'sd1, -16'sd32768, -16'sd32768, 1'b0, none},
            '{-16'sd1, 16'sd1, 16'sd0, 1'b0, none},
            '{16'sd3, 16'sd7, 16'sd2, 1'b0, none},
            '{-16'sd5, 16'sd3, 16'sd9, 1'b0, none},
            '{16'sd2, -16'sd3, 16'sd5, 1'b0, none},
            '{-16'sd3, -16'sd12, -16'sd12, 1'b0, none}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            cs = '{rows[i].a, rows[i].b, rows[i].c};
            issue_coefs(cs, rows[i].typed, rows[i].want);
        end
        wait_drained();

        // Each cycle is idle with the phase's probability, otherwise it carries a transaction.
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 50 : (phase == 3) ? 33 : 0;
            for (int n = 0; n < 420; ) begin
                if ($urandom_range(0, 99) < idle_pct) begin
                    idle_for(1);
                end else begin
                    issue_coefs(random_coefs(), 1'b0, none);
                    n++;
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_roots.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/qrs_pkg.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver.sv
bench/tb.sv
